// ----- rtl/core/ucpe_pkg.sv -----
package ucpe_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_ENCODING = 2'd0;
  localparam logic [1:0] CFG_BOM_MODE = 2'd1;

  // encoding_select codes
  localparam logic [2:0] SEL_UTF8  = 3'd0;
  localparam logic [2:0] SEL_U16LE = 3'd1;
  localparam logic [2:0] SEL_U16BE = 3'd2;
  localparam logic [2:0] SEL_U32LE = 3'd3;
  localparam logic [2:0] SEL_U32BE = 3'd4;
  localparam logic [2:0] SEL_U16   = 3'd5;
  localparam logic [2:0] SEL_U32   = 3'd6;

  // bom_mode codes
  localparam logic [1:0] BOM_DEFAULT = 2'd0;
  localparam logic [1:0] BOM_REQUIRE = 2'd1;
  localparam logic [1:0] BOM_REJECT  = 2'd2;

  localparam logic [20:0] MAX_CODE_POINT   = 21'h10ffff;
  localparam logic [20:0] REPLACEMENT_CHAR = 21'h00fffd;
  localparam logic [20:0] SUPP_BASE        = 21'h010000;
  localparam logic [15:0] HIGH_SURR        = 16'hd800;
  localparam logic [15:0] LOW_SURR         = 16'hdc00;
  localparam logic [15:0] BOM_UNIT         = 16'hfeff;

  localparam logic [7:0] UTF8_BOM0  = 8'hef;
  localparam logic [7:0] UTF8_BOM1  = 8'hbb;
  localparam logic [7:0] UTF8_BOM2  = 8'hbf;
  localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0] UTF8_LEAD3 = 8'he0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hf0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  typedef enum logic [2:0] {
    ENC_UTF8,
    ENC_U16LE,
    ENC_U16BE,
    ENC_U32LE,
    ENC_U32BE
  } enc_t;

  // decoded item, first pipeline stage
  typedef struct packed {
    logic        bom_en;
    logic        carries;
    enc_t        enc;
    logic [20:0] cp;
  } dec_t;

  // byte groups, second pipeline stage; byte 0 goes out first
  typedef struct packed {
    logic [3:0][7:0] bom_bytes;
    logic [2:0]      bom_n;
    logic [3:0][7:0] chr_bytes;
    logic [2:0]      chr_n;
  } pack_t;

endpackage

// ----- rtl/core/ucpe_decode.sv -----
module ucpe_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [2:0]      enc_sel,
  input  logic [1:0]      bom_mode,
  input  logic            up_valid,
  output logic            up_ready,
  input  logic [20:0]     code_point,
  input  logic            begins_text,
  input  logic            carries_char,
  output logic            dn_valid,
  input  logic            dn_ready,
  output ucpe_pkg::dec_t  dn_data
);
  import ucpe_pkg::*;

  logic  valid_r;
  dec_t  data_r;
  dec_t  data_nxt;
  enc_t  enc;
  logic  applies;

  always_comb begin
    case (enc_sel)
      SEL_U16LE, SEL_U16: enc = ENC_U16LE;
      SEL_U16BE:          enc = ENC_U16BE;
      SEL_U32LE, SEL_U32: enc = ENC_U32LE;
      SEL_U32BE:          enc = ENC_U32BE;
      default:            enc = ENC_UTF8;
    endcase
  end

  // unused mode code falls back to default behaviour
  assign applies = (bom_mode != BOM_REJECT) &&
                   ((bom_mode == BOM_REQUIRE) || (enc != ENC_UTF8));

  always_comb begin
    data_nxt.bom_en  = begins_text && applies;
    data_nxt.carries = carries_char;
    data_nxt.enc     = enc;
    data_nxt.cp      = (code_point > MAX_CODE_POINT) ? REPLACEMENT_CHAR : code_point;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- rtl/core/ucpe_pack.sv -----
module ucpe_pack (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  ucpe_pkg::dec_t   up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output ucpe_pkg::pack_t  dn_data
);
  import ucpe_pkg::*;

  logic        valid_r;
  pack_t       data_r;
  pack_t       data_nxt;
  logic [20:0] v;
  logic [20:0] u;
  logic [15:0] hi_unit;
  logic [15:0] lo_unit;
  logic [7:0]  plane;

  assign v       = up_data.cp;
  assign u       = v - SUPP_BASE;
  assign hi_unit = HIGH_SURR | {6'b0, u[19:10]};
  assign lo_unit = LOW_SURR | {6'b0, u[9:0]};
  assign plane   = {3'b0, v[20:16]};

  always_comb begin
    data_nxt.bom_bytes = '0;
    data_nxt.bom_n     = 3'd0;
    data_nxt.chr_bytes = '0;
    data_nxt.chr_n     = 3'd0;

    case (up_data.enc)
      ENC_U16LE: begin
        data_nxt.bom_bytes[0] = BOM_UNIT[7:0];
        data_nxt.bom_bytes[1] = BOM_UNIT[15:8];
        data_nxt.bom_n        = 3'd2;
      end
      ENC_U16BE: begin
        data_nxt.bom_bytes[0] = BOM_UNIT[15:8];
        data_nxt.bom_bytes[1] = BOM_UNIT[7:0];
        data_nxt.bom_n        = 3'd2;
      end
      ENC_U32LE: begin
        data_nxt.bom_bytes[0] = BOM_UNIT[7:0];
        data_nxt.bom_bytes[1] = BOM_UNIT[15:8];
        data_nxt.bom_n        = 3'd4;
      end
      ENC_U32BE: begin
        data_nxt.bom_bytes[2] = BOM_UNIT[15:8];
        data_nxt.bom_bytes[3] = BOM_UNIT[7:0];
        data_nxt.bom_n        = 3'd4;
      end
      default: begin
        data_nxt.bom_bytes[0] = UTF8_BOM0;
        data_nxt.bom_bytes[1] = UTF8_BOM1;
        data_nxt.bom_bytes[2] = UTF8_BOM2;
        data_nxt.bom_n        = 3'd3;
      end
    endcase

    case (up_data.enc)
      ENC_U16LE, ENC_U16BE: begin
        if (v[20:16] == 5'd0) begin
          data_nxt.chr_bytes[0] = v[7:0];
          data_nxt.chr_bytes[1] = v[15:8];
          data_nxt.chr_n        = 3'd2;
        end else begin
          data_nxt.chr_bytes[0] = hi_unit[7:0];
          data_nxt.chr_bytes[1] = hi_unit[15:8];
          data_nxt.chr_bytes[2] = lo_unit[7:0];
          data_nxt.chr_bytes[3] = lo_unit[15:8];
          data_nxt.chr_n        = 3'd4;
        end
        // big endian: swap within each unit
        if (up_data.enc == ENC_U16BE) begin
          data_nxt.chr_bytes = {data_nxt.chr_bytes[2], data_nxt.chr_bytes[3],
                                data_nxt.chr_bytes[0], data_nxt.chr_bytes[1]};
        end
      end
      ENC_U32LE: begin
        data_nxt.chr_bytes[0] = v[7:0];
        data_nxt.chr_bytes[1] = v[15:8];
        data_nxt.chr_bytes[2] = plane;
        data_nxt.chr_n        = 3'd4;
      end
      ENC_U32BE: begin
        data_nxt.chr_bytes[1] = plane;
        data_nxt.chr_bytes[2] = v[15:8];
        data_nxt.chr_bytes[3] = v[7:0];
        data_nxt.chr_n        = 3'd4;
      end
      default: begin
        if (v <= 21'h00007f) begin
          data_nxt.chr_bytes[0] = v[7:0];
          data_nxt.chr_n        = 3'd1;
        end else if (v <= 21'h0007ff) begin
          data_nxt.chr_bytes[0] = UTF8_LEAD2 | {3'b0, v[10:6]};
          data_nxt.chr_bytes[1] = UTF8_CONT | {2'b0, v[5:0]};
          data_nxt.chr_n        = 3'd2;
        end else if (v <= 21'h00ffff) begin
          data_nxt.chr_bytes[0] = UTF8_LEAD3 | {4'b0, v[15:12]};
          data_nxt.chr_bytes[1] = UTF8_CONT | {2'b0, v[11:6]};
          data_nxt.chr_bytes[2] = UTF8_CONT | {2'b0, v[5:0]};
          data_nxt.chr_n        = 3'd3;
        end else begin
          data_nxt.chr_bytes[0] = UTF8_LEAD4 | {5'b0, v[20:18]};
          data_nxt.chr_bytes[1] = UTF8_CONT | {2'b0, v[17:12]};
          data_nxt.chr_bytes[2] = UTF8_CONT | {2'b0, v[11:6]};
          data_nxt.chr_bytes[3] = UTF8_CONT | {2'b0, v[5:0]};
          data_nxt.chr_n        = 3'd4;
        end
      end
    endcase

    if (!up_data.bom_en) begin
      data_nxt.bom_n = 3'd0;
    end
    if (!up_data.carries) begin
      data_nxt.chr_n = 3'd0;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- rtl/core/ucpe_serial.sv -----
module ucpe_serial (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  ucpe_pkg::pack_t  up_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last
);
  import ucpe_pkg::*;

  logic       hold_valid_r;
  pack_t      hold_r;
  logic [2:0] idx_r;
  logic [2:0] idx_nxt;
  logic [2:0] chr_idx;
  logic [3:0] total;
  logic       at_last;
  logic       out_free;
  logic       emit;
  logic       done;
  logic [7:0] sel_byte;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  assign total    = {1'b0, hold_r.bom_n} + {1'b0, hold_r.chr_n};
  assign at_last  = ({1'b0, idx_r} == (total - 4'd1));
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = hold_valid_r && (total != 4'd0) && out_free;
  // an item without bytes retires at once
  assign done     = hold_valid_r && ((total == 4'd0) || (emit && at_last));
  assign up_ready = !hold_valid_r || done;
  assign chr_idx  = idx_r - hold_r.bom_n;

  always_comb begin
    if (idx_r < hold_r.bom_n) begin
      sel_byte = hold_r.bom_bytes[idx_r[1:0]];
    end else begin
      sel_byte = hold_r.chr_bytes[chr_idx[1:0]];
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (up_ready) begin
      idx_nxt = 3'd0;
    end else if (emit) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      idx_r        <= 3'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (up_ready) begin
        hold_valid_r <= up_valid;
      end
      idx_r <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      hold_r <= up_data;
    end
    if (emit) begin
      out_byte_r <= sel_byte;
      out_last_r <= at_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

`ifndef ASSERT_OFF
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid_r && (total != 4'd0)) |-> ({1'b0, idx_r} < total))
    else $error("byte index past end of item");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> (total <= 4'd8))
    else $error("item byte count above eight");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && (out_last_r == $past(at_last))))
    else $error("emitted byte not presented");
`endif

endmodule

// ----- rtl/core/unicode_code_point_byte_encoder.sv -----
// Unicode code point byte encoder: each input transaction carries at most one code point and
// produces its bytes as output transactions, one byte each, in the encoding picked by
// encoding_select (UTF-8, UTF-16 or UTF-32, little or big endian, generic codes meaning little
// endian); a transaction with begins_text set is preceded by the byte order mark when bom_mode
// allows it, and out_last_byte marks the final byte of each input transaction. Values above
// 0x10FFFF are sent as U+FFFD. An input transaction has N bytes (BOM plus character, 0 to 8);
// the serialiser takes a new one as it sends the last byte of the current one, so ASCII in
// UTF-8 runs at one per cycle while out_stall is low; the byte-wide output register sets this
// rate. Decode and byte-packing stages accept a transaction every cycle while their output is
// taken; each registers it, as does the serialiser, before the first byte. Configuration is
// taken from the registers directly and must only change while the block is idle.
module unicode_code_point_byte_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [20:0] in_code_point,
  input  logic        in_begins_text,
  input  logic        in_carries_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_byte
);
  import ucpe_pkg::*;

  // configuration registers
  logic [2:0] enc_sel_r;
  logic [2:0] enc_sel_nxt;
  logic [1:0] bom_mode_r;
  logic [1:0] bom_mode_nxt;

  // pipeline links
  logic  in_ready;
  logic  dec_valid;
  logic  dec_ready;
  dec_t  dec_data;
  logic  pack_valid;
  logic  pack_ready;
  pack_t pack_data;

  // writes to unknown indexes are dropped
  always_comb begin
    enc_sel_nxt  = enc_sel_r;
    bom_mode_nxt = bom_mode_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ENCODING: enc_sel_nxt  = cfg_wr_data;
        CFG_BOM_MODE: bom_mode_nxt = cfg_wr_data[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_sel_r  <= SEL_UTF8;
      bom_mode_r <= BOM_DEFAULT;
    end else begin
      enc_sel_r  <= enc_sel_nxt;
      bom_mode_r <= bom_mode_nxt;
    end
  end

  // stage 1: concrete encoding, bom decision, replacement of out-of-range values
  ucpe_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .enc_sel      (enc_sel_r),
    .bom_mode     (bom_mode_r),
    .up_valid     (in_valid),
    .up_ready     (in_ready),
    .code_point   (in_code_point),
    .begins_text  (in_begins_text),
    .carries_char (in_carries_char),
    .dn_valid     (dec_valid),
    .dn_ready     (dec_ready),
    .dn_data      (dec_data)
  );

  // stage 2: bom bytes and character bytes with their counts
  ucpe_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_data  (dec_data),
    .dn_valid (pack_valid),
    .dn_ready (pack_ready),
    .dn_data  (pack_data)
  );

  // stage 3 and output register: one byte per cycle while out_stall is low
  ucpe_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (pack_valid),
    .up_ready  (pack_ready),
    .up_data   (pack_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last_byte)
  );

  assign in_stall = !in_ready;

endmodule
